// File: design/byte_stream_reassembler_core_defines.svh
// Assertion macros for the byte stream reassembler checker.
// Used by bsr_checker; expects clk and rst in the enclosing scope.
`ifndef BYTE_STREAM_REASSEMBLER_CORE_DEFINES_SVH
`define BYTE_STREAM_REASSEMBLER_CORE_DEFINES_SVH

// same-cycle implication
`define BSR_ASSERT_IMP(name, cond, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("bsr_checker: assertion failed");

// next-cycle implication
`define BSR_ASSERT_NXT(name, cond, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("bsr_checker: assertion failed");

`endif

// File: design/bsr_pkg.sv
// Shared constants and types for the byte stream reassembler.
// No dependencies.
`timescale 1ns / 1ps
package bsr_pkg;

  localparam int CAPACITY_DEFAULT = 64;
  localparam int BYTE_W           = 8;
  localparam int POS_W            = 32;
  localparam int CNT_W            = 7;
  localparam int OP_W             = 2;

  localparam logic [OP_W-1:0] OP_BYTE    = 2'd0;
  localparam logic [OP_W-1:0] OP_END     = 2'd1;
  localparam logic [OP_W-1:0] OP_CONSUME = 2'd2;

  typedef struct packed {
    logic              full;
    logic [BYTE_W-1:0] data;
  } slot_t;

  typedef struct packed {
    logic shift;
    logic write;
  } cell_ctl_t;

endpackage

// File: design/bsr_cell.sv
// One slot cell of the reassembly row: a byte and its full flag.
// Shifts in its upper neighbor's slot or takes a write if empty. Uses bsr_pkg.
`timescale 1ns / 1ps
module bsr_cell (
  input  logic                      clk,
  input  logic                      rst,
  input  bsr_pkg::cell_ctl_t        ctl,
  input  bsr_pkg::slot_t            nbr,
  input  logic [bsr_pkg::BYTE_W-1:0] wbyte,
  output bsr_pkg::slot_t            q
);
  import bsr_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      q.full <= 1'b0;
    end else if (ctl.shift) begin
      q.full <= nbr.full;
    end else if (ctl.write && !q.full) begin
      q.full <= 1'b1;
    end
  end

  // first byte kept in a slot wins
  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      q.data <= nbr.data;
    end else if (ctl.write && !q.full) begin
      q.data <= wbyte;
    end
  end

endmodule

// File: design/bsr_cell_row.sv
// Row of slot cells; cell 0 is the stream head, the row shifts toward it on drain.
// Depends on bsr_pkg and bsr_cell.
`timescale 1ns / 1ps
module bsr_cell_row #(
  parameter int CAPACITY = bsr_pkg::CAPACITY_DEFAULT,
  parameter int CW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  bsr_pkg::cell_ctl_t         ctl,
  input  logic [CW-1:0]              widx,
  input  logic [bsr_pkg::BYTE_W-1:0] wbyte,
  output bsr_pkg::slot_t             head,
  output logic                       next_full,
  output logic                       idx_full
);
  import bsr_pkg::*;

  slot_t             slots [CAPACITY];
  slot_t             nbr   [CAPACITY];
  cell_ctl_t         cctl  [CAPACITY];
  logic [2**CW-1:0]  full_pad;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == CAPACITY - 1) begin : g_tail
      assign nbr[i] = '{full: 1'b0, data: '0};
    end else begin : g_mid
      assign nbr[i] = slots[i+1];
    end

    assign cctl[i].shift = ctl.shift;
    assign cctl[i].write = ctl.write && (widx == CW'(i));

    bsr_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .ctl   (cctl[i]),
      .nbr   (nbr[i]),
      .wbyte (wbyte),
      .q     (slots[i])
    );
  end

  always_comb begin
    full_pad = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      full_pad[i] = slots[i].full;
    end
  end

  assign head     = slots[0];
  assign idx_full = full_pad[widx];

  if (CAPACITY > 1) begin : g_next
    assign next_full = slots[1].full;
  end else begin : g_single
    assign next_full = 1'b0;
  end

endmodule

// File: design/byte_stream_reassembler_core.sv
// byte_stream_reassembler_core: out-of-order byte reassembler over a shifting row of slot cells.
// The item is registered on accept, applied in ST_APPLY, then drained in ST_DRAIN to the output registers.
// An item holds the block busy through ST_APPLY and ST_DRAIN for its n results (1..CAPACITY),
// one result per cycle, set by the cell row shifting one slot toward the head per byte.
// Sync reset: all slots empty, positions and counts zero, eof unknown; results never stall.
`timescale 1ns / 1ps
module byte_stream_reassembler_core #(
  parameter int CAPACITY = bsr_pkg::CAPACITY_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [bsr_pkg::OP_W-1:0]   opcode,
  input  logic [bsr_pkg::BYTE_W-1:0] byte_value,
  input  logic [bsr_pkg::POS_W-1:0]  stream_position,
  input  logic                       segment_eof,
  input  logic [bsr_pkg::CNT_W-1:0]  consumed_count,
  output logic                       result_strobe,
  output logic                       out_valid,
  output logic [bsr_pkg::BYTE_W-1:0] out_byte,
  output logic                       run_last,
  output logic                       stream_ended,
  output logic [bsr_pkg::CNT_W-1:0]  unassembled_count,
  output logic                       is_empty
);
  import bsr_pkg::*;

  localparam int CW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int HW = $clog2(CAPACITY + 1);
  localparam logic [HW-1:0] CAP_H = HW'(CAPACITY);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_APPLY = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  state_t state, state_next;

  logic [OP_W-1:0]   op_r;
  logic [BYTE_W-1:0] byte_r;
  logic [POS_W-1:0]  pos_r;
  logic              eof_r;
  logic [CNT_W-1:0]  cons_r;

  logic [POS_W-1:0] next_pos, next_pos_next;
  logic [HW-1:0]    held, held_next;
  logic [HW-1:0]    waiting, waiting_next;
  logic [HW-1:0]    eof_gap, eof_gap_next;
  logic             eof_known, eof_known_next;

  logic              res_valid, res_last, res_ended;
  logic [BYTE_W-1:0] res_byte;
  logic [HW-1:0]     res_count;
  logic              res_strobe;

  logic [POS_W-1:0] off;
  logic [HW-1:0]    free_win;
  logic [HW-1:0]    cons_c;
  logic             in_win, past_eof, store, ended, can_drain, stop_after;

  cell_ctl_t row_ctl;
  slot_t     head;
  logic      next_full, idx_full;

  bsr_cell_row #(
    .CAPACITY (CAPACITY),
    .CW       (CW)
  ) u_row (
    .clk       (clk),
    .rst       (rst),
    .ctl       (row_ctl),
    .widx      (off[CW-1:0]),
    .wbyte     (byte_r),
    .head      (head),
    .next_full (next_full),
    .idx_full  (idx_full)
  );

  assign busy     = (state != ST_IDLE);
  assign off      = pos_r - next_pos;
  assign free_win = CAP_H - held;
  assign in_win   = off < POS_W'(free_win);
  assign past_eof = eof_known && (off >= POS_W'(eof_gap));
  assign store    = (op_r == OP_BYTE) && in_win && !past_eof;
  assign cons_c   = (cons_r > CNT_W'(held)) ? held : HW'(cons_r);

  assign ended      = eof_known && (eof_gap == '0);
  assign can_drain  = head.full && !ended;
  assign stop_after = !next_full || (eof_known && (eof_gap == HW'(1)));

  always_comb begin
    state_next     = state;
    next_pos_next  = next_pos;
    held_next      = held;
    waiting_next   = waiting;
    eof_gap_next   = eof_gap;
    eof_known_next = eof_known;
    row_ctl        = '{shift: 1'b0, write: 1'b0};
    res_strobe     = 1'b0;
    res_valid      = 1'b0;
    res_byte       = '0;
    res_last       = 1'b1;
    res_ended      = ended;
    res_count      = waiting;

    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_APPLY;
        end
      end
      ST_APPLY: begin
        state_next = ST_DRAIN;
        case (op_r)
          OP_BYTE: begin
            row_ctl.write = store;
            if (store && !idx_full) begin
              waiting_next = waiting + HW'(1);
            end
          end
          OP_END: begin
            if (eof_r && !eof_known) begin
              if (off <= POS_W'(free_win)) begin
                eof_known_next = 1'b1;
                eof_gap_next   = off[HW-1:0];
              end else if (off[POS_W-1]) begin
                eof_known_next = 1'b1;
                eof_gap_next   = '0;
              end
            end
          end
          OP_CONSUME: begin
            held_next = held - cons_c;
          end
          default: begin
          end
        endcase
      end
      ST_DRAIN: begin
        res_strobe = 1'b1;
        if (can_drain) begin
          row_ctl.shift = 1'b1;
          next_pos_next = next_pos + POS_W'(1);
          held_next     = held + HW'(1);
          waiting_next  = (waiting != '0) ? waiting - HW'(1) : waiting;
          if (eof_known) begin
            eof_gap_next = eof_gap - HW'(1);
          end
          res_valid  = 1'b1;
          res_byte   = head.data;
          res_last   = stop_after;
          res_ended  = eof_known && (eof_gap == HW'(1));
          res_count  = waiting_next;
          state_next = stop_after ? ST_IDLE : ST_DRAIN;
        end else begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      next_pos      <= '0;
      held          <= '0;
      waiting       <= '0;
      eof_gap       <= '0;
      eof_known     <= 1'b0;
      result_strobe <= 1'b0;
    end else begin
      state         <= state_next;
      next_pos      <= next_pos_next;
      held          <= held_next;
      waiting       <= waiting_next;
      eof_gap       <= eof_gap_next;
      eof_known     <= eof_known_next;
      result_strobe <= res_strobe;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      op_r   <= opcode;
      byte_r <= byte_value;
      pos_r  <= stream_position;
      eof_r  <= segment_eof;
      cons_r <= consumed_count;
    end
    if (res_strobe) begin
      out_valid         <= res_valid;
      out_byte          <= res_byte;
      run_last          <= res_last;
      stream_ended      <= res_ended;
      unassembled_count <= CNT_W'(res_count);
      is_empty          <= (res_count == '0);
    end
  end

endmodule

// File: design/bsr_checker.sv
// Port-level checker for byte_stream_reassembler_core, bound into each instance of it.
// Depends on bsr_pkg and byte_stream_reassembler_core_defines.svh.
`timescale 1ns / 1ps
`include "byte_stream_reassembler_core_defines.svh"
module bsr_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       start,
  input logic                       busy,
  input logic                       result_strobe,
  input logic                       out_valid,
  input logic [bsr_pkg::BYTE_W-1:0] out_byte,
  input logic                       run_last,
  input logic [bsr_pkg::CNT_W-1:0]  unassembled_count,
  input logic                       is_empty
);
  import bsr_pkg::*;

  `BSR_ASSERT_NXT(a_accept_busy, start && !busy, busy)
  `BSR_ASSERT_IMP(a_last_frees, result_strobe, busy != run_last)
  `BSR_ASSERT_IMP(a_status_item, result_strobe && !out_valid, run_last && (out_byte == '0))
  `BSR_ASSERT_IMP(a_empty_flag, result_strobe, is_empty == (unassembled_count == '0))

endmodule

bind byte_stream_reassembler_core bsr_checker u_bsr_checker (.*);

// File: tb/sv/tb.sv
// Self-checking testbench for byte_stream_reassembler_core: directed rows, then random
// segment, consume and noise items, results checked by typed wants or a predictor.
// Depends on bsr_pkg and byte_stream_reassembler_core.
`timescale 1ns / 1ps
module tb;
  import bsr_pkg::*;

  localparam int CAP = CAPACITY_DEFAULT;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 240;
  localparam int QUIET_LIMIT = 2000;

  typedef struct packed {
    logic             valid;
    logic [BYTE_W-1:0] data;
    logic             last;
    logic             ended;
    logic [CNT_W-1:0] count;
    logic             empty;
  } bsr_result_t;

  typedef struct {
    logic [OP_W-1:0]   op;
    logic [BYTE_W-1:0] data;
    logic [POS_W-1:0]  pos;
    logic              eof;
    logic [CNT_W-1:0]  consumed;
    logic              typed;
    bsr_result_t       want;
  } stim_row_t;

  localparam bsr_result_t NO_RESULT  = '0;
  localparam bsr_result_t IDLE_EMPTY = '{valid: 1'b0, data: 8'h00, last: 1'b1, ended: 1'b0,
                                         count: 7'd0, empty: 1'b1};
  localparam bsr_result_t IDLE_ONE   = '{valid: 1'b0, data: 8'h00, last: 1'b1, ended: 1'b0,
                                         count: 7'd1, empty: 1'b0};

  logic              clk;
  logic              rst;
  logic              start;
  logic              busy;
  logic [OP_W-1:0]   opcode;
  logic [BYTE_W-1:0] byte_value;
  logic [POS_W-1:0]  stream_position;
  logic              segment_eof;
  logic [CNT_W-1:0]  consumed_count;
  logic              result_strobe;
  logic              out_valid;
  logic [BYTE_W-1:0] out_byte;
  logic              run_last;
  logic              stream_ended;
  logic [CNT_W-1:0]  unassembled_count;
  logic              is_empty;

  byte_stream_reassembler_core i_dut (.*);

  // predictor state
  logic [BYTE_W-1:0] slot_bytes [CAP];
  logic [CAP-1:0]    slot_held;
  logic [5:0]        head;
  logic [POS_W-1:0]  next_pos;
  logic [POS_W-1:0]  read_pos;
  logic [POS_W-1:0]  eof_pos;
  logic [CNT_W-1:0]  waiting;
  logic              eof_seen;

  bsr_result_t awaited_results [$];
  bsr_result_t drained_run [$];
  stim_row_t   directed_rows [$];
  int          errors;
  int          items_sent;
  int          idle_pct;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [POS_W-1:0] window_room();
    logic [POS_W-1:0] held;
    held = next_pos - read_pos;
    return (held > CAP) ? '0 : CAP - held;
  endfunction

  function automatic logic stream_done();
    return eof_seen && next_pos == eof_pos;
  endfunction

  function automatic void reassemble_item(logic [OP_W-1:0] op, logic [BYTE_W-1:0] data,
                                          logic [POS_W-1:0] pos, logic eof,
                                          logic [CNT_W-1:0] consumed);
    logic [POS_W-1:0] off;
    logic [POS_W-1:0] room;
    logic [POS_W-1:0] held;
    logic [5:0]       slot;
    bsr_result_t      r;
    drained_run.delete();
    room = window_room();
    held = next_pos - read_pos;
    off  = pos - next_pos;
    case (op)
      OP_BYTE: begin
        if (off < room && !(eof_seen && off >= eof_pos - next_pos)) begin
          slot = head + off[5:0];
          if (!slot_held[slot]) begin
            slot_bytes[slot] = data;
            slot_held[slot]  = 1'b1;
            waiting++;
          end
        end
      end
      OP_END: begin
        if (eof && !eof_seen) begin
          if (off <= room) begin
            eof_seen = 1'b1;
            eof_pos  = pos;
          end else if (off[POS_W-1]) begin
            eof_seen = 1'b1;
            eof_pos  = next_pos;
          end
        end
      end
      OP_CONSUME: read_pos += (POS_W'(consumed) > held) ? held : POS_W'(consumed);
      default: ;
    endcase
    while (drained_run.size() < CAP && slot_held[head] && !stream_done()) begin
      r.valid = 1'b1;
      r.data  = slot_bytes[head];
      slot_held[head] = 1'b0;
      head++;
      next_pos++;
      if (waiting != 0) waiting--;
      r.last  = 1'b0;
      r.ended = stream_done();
      r.count = waiting;
      r.empty = (waiting == 0);
      drained_run = {drained_run, r};
    end
    if (drained_run.size() == 0) begin
      r = '{valid: 1'b0, data: 8'h00, last: 1'b1, ended: stream_done(), count: waiting,
            empty: waiting == 0};
      drained_run = {drained_run, r};
    end else begin
      drained_run[drained_run.size() - 1].last = 1'b1;
    end
  endfunction

  task automatic send_item(logic [OP_W-1:0] op, logic [BYTE_W-1:0] data, logic [POS_W-1:0] pos,
                           logic eof, logic [CNT_W-1:0] consumed, logic typed = 1'b0,
                           bsr_result_t want = NO_RESULT);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start           <= 1'b1;
    opcode          <= op;
    byte_value      <= data;
    stream_position <= pos;
    segment_eof     <= eof;
    consumed_count  <= consumed;
    do @(posedge clk); while (busy);
    reassemble_item(op, data, pos, eof, consumed);
    if (typed) awaited_results = {awaited_results, want};
    else awaited_results = {awaited_results, drained_run};
    items_sent++;
  endtask

  task automatic send_consume();
    logic [CNT_W-1:0] cnt;
    cnt = ($urandom_range(3) == 0) ? CNT_W'($urandom) : CNT_W'(next_pos - read_pos);
    send_item(OP_CONSUME, BYTE_W'($urandom), $urandom, 1'($urandom), cnt);
  endtask

  // a run of bytes, sent in order, reversed or shuffled, sometimes with a duplicate
  task automatic send_segment();
    logic [POS_W-1:0] room;
    logic [POS_W-1:0] lead;
    logic [POS_W-1:0] base;
    int len;
    int span;
    int mode;
    int j;
    int tmp;
    int order [$];
    room = window_room();
    if ($urandom_range(7) == 0) begin
      lead = '0;
      len  = int'(room);
    end else begin
      lead = $urandom_range(room > 4 ? 4 : int'(room) - 1);
      span = int'(room - lead);
      len  = 1 + $urandom_range(span > 16 ? 15 : span - 1);
    end
    mode = $urandom_range(2);
    for (int i = 0; i < len; i++) order = {order, (mode == 1) ? len - 1 - i : i};
    if (mode == 2) begin
      for (int i = len - 1; i > 0; i--) begin
        j = $urandom_range(i);
        tmp = order[i];
        order[i] = order[j];
        order[j] = tmp;
      end
    end
    if ($urandom_range(3) == 0) order = {order, order[$urandom_range(len - 1)]};
    base = next_pos + lead;
    foreach (order[i])
      send_item(OP_BYTE, BYTE_W'($urandom), base + order[i], 1'($urandom), CNT_W'($urandom));
  endtask

  task automatic send_noise();
    logic [OP_W-1:0]  op;
    logic [POS_W-1:0] pos;
    logic             eof;
    op  = OP_W'($urandom);
    pos = $urandom;
    eof = 1'($urandom);
    // an end mark with eof set only lands beyond the window, so the stream stays open
    if (op == OP_END && eof) pos = next_pos + window_room() + 1 + ($urandom & 32'h3FFF_FFFF);
    send_item(op, BYTE_W'($urandom), pos, eof, CNT_W'($urandom));
  endtask

  task automatic drain_pause();
    start <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  function automatic void add_row(logic [OP_W-1:0] op, logic [BYTE_W-1:0] data,
                                  logic [POS_W-1:0] pos, logic eof, logic [CNT_W-1:0] consumed,
                                  logic typed, bsr_result_t want);
    stim_row_t row;
    row = '{op, data, pos, eof, consumed, typed, want};
    directed_rows = {directed_rows, row};
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    bsr_result_t want;
    if (!rst && result_strobe) begin
      if (awaited_results.size() == 0) begin
        $error("unexpected result: out_valid=%0b out_byte=%0h", out_valid, out_byte);
        errors++;
      end else begin
        want = awaited_results[0];
        awaited_results.delete(0);
        check_field("out_valid", 32'(want.valid), 32'(out_valid));
        check_field("out_byte", 32'(want.data), 32'(out_byte));
        check_field("run_last", 32'(want.last), 32'(run_last));
        check_field("stream_ended", 32'(want.ended), 32'(stream_ended));
        check_field("unassembled_count", 32'(want.count), 32'(unassembled_count));
        check_field("is_empty", 32'(want.empty), 32'(is_empty));
      end
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (start && !busy) || result_strobe) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    int idle_plan [4];
    int phase_end;
    int sel;
    logic [POS_W-1:0] base;
    logic [POS_W-1:0] end_at;
    logic [POS_W-1:0] room;
    idle_plan = '{0, 79, 32, 0};
    errors     = 0;
    items_sent = 0;
    idle_pct   = 32;
    slot_held  = '0;
    head       = '0;
    next_pos   = '0;
    read_pos   = '0;
    eof_pos    = '0;
    waiting    = '0;
    eof_seen   = 1'b0;
    foreach (slot_bytes[i]) slot_bytes[i] = '0;
    rst             = 1'b1;
    start           = 1'b0;
    opcode          = OP_BYTE;
    byte_value      = '0;
    stream_position = '0;
    segment_eof     = 1'b0;
    consumed_count  = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    add_row(OP_UNUSED,  8'h00, 32'd0,          1'b0, 7'd0,   1'b1, IDLE_EMPTY);
    add_row(OP_BYTE,    8'hFF, 32'hFFFF_FFFF,  1'b0, 7'd0,   1'b1, IDLE_EMPTY);
    add_row(OP_BYTE,    8'h00, 32'd63,         1'b0, 7'd0,   1'b1, IDLE_ONE);
    add_row(OP_BYTE,    8'hAA, 32'd64,         1'b0, 7'd0,   1'b1, IDLE_ONE);
    add_row(OP_BYTE,    8'h11, 32'd63,         1'b0, 7'd0,   1'b1, IDLE_ONE);
    add_row(OP_CONSUME, 8'h00, 32'd0,          1'b0, 7'd64,  1'b1, IDLE_ONE);
    add_row(OP_END,     8'h00, 32'd100,        1'b0, 7'd0,   1'b1, IDLE_ONE);
    add_row(OP_END,     8'h00, 32'd65,         1'b1, 7'd0,   1'b1, IDLE_ONE);
    add_row(OP_END,     8'h00, 32'h7FFF_FFFF,  1'b1, 7'd0,   1'b1, IDLE_ONE);
    add_row(OP_BYTE,    8'h80, 32'd1,          1'b0, 7'd0,   1'b0, NO_RESULT);
    add_row(OP_BYTE,    8'h01, 32'd0,          1'b1, 7'd127, 1'b0, NO_RESULT);
    add_row(OP_CONSUME, 8'hFF, 32'hFFFF_FFFF,  1'b1, 7'd127, 1'b0, NO_RESULT);
    add_row(OP_BYTE,    8'hC3, 32'd2,          1'b0, 7'd0,   1'b0, NO_RESULT);
    add_row(OP_CONSUME, 8'h00, 32'd0,          1'b0, 7'd0,   1'b0, NO_RESULT);
    add_row(OP_BYTE,    8'h3C, 32'd66,         1'b0, 7'd0,   1'b0, NO_RESULT);
    add_row(OP_BYTE,    8'h7E, 32'd65,         1'b0, 7'd0,   1'b0, NO_RESULT);
    add_row(OP_BYTE,    8'h55, 32'h8000_0000,  1'b0, 7'd0,   1'b0, NO_RESULT);
    add_row(OP_UNUSED,  8'hFF, 32'hFFFF_FFFF,  1'b1, 7'd127, 1'b0, NO_RESULT);
    foreach (directed_rows[i])
      send_item(directed_rows[i].op, directed_rows[i].data, directed_rows[i].pos,
                directed_rows[i].eof, directed_rows[i].consumed, directed_rows[i].typed,
                directed_rows[i].want);

    phase_end = items_sent;
    for (int ph = 0; ph < 4; ph++) begin
      drain_pause();
      idle_pct  = idle_plan[ph];
      phase_end += RANDOM_ITEMS / 4;
      while (items_sent < phase_end) begin
        sel = $urandom_range(99);
        if (window_room() == 0 || sel < 25) send_consume();
        else if (sel < 85) send_segment();
        else send_noise();
      end
    end

    // close the stream: either an end mark inside the window or one behind next
    idle_pct = 32;
    send_item(OP_CONSUME, 8'h00, 32'd0, 1'b0, CNT_W'(next_pos - read_pos));
    base = next_pos;
    room = window_room();
    if ($urandom_range(1) == 1) begin
      end_at = base + ((room < 6) ? room : 6);
      send_item(OP_END, BYTE_W'($urandom), end_at, 1'b1, CNT_W'($urandom));
      for (int k = int'(end_at - base) + 1; k >= 0; k--)
        send_item(OP_BYTE, BYTE_W'($urandom), base + k, 1'b0, 7'd0);
    end else begin
      send_item(OP_END, BYTE_W'($urandom), base - 1 - $urandom_range(999), 1'b1, 7'd0);
    end
    send_item(OP_END, 8'h00, next_pos + 1, 1'b1, 7'd0);
    send_item(OP_BYTE, 8'hA5, next_pos, 1'b0, 7'd0);
    send_item(OP_CONSUME, 8'h00, 32'd0, 1'b0, 7'd127);
    send_item(OP_UNUSED, 8'h00, 32'd0, 1'b0, 7'd0);

    start <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (CAP + 8) @(posedge clk);
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule

// File: filelist.f
+incdir+design
design/bsr_pkg.sv
design/bsr_cell.sv
design/bsr_cell_row.sv
design/byte_stream_reassembler_core.sv
design/bsr_checker.sv
tb/sv/tb.sv
